FILE: hdl/avva_pkg.sv
// Shared types, constants and the arctangent table for the aiming unit.
package avva_pkg;

  localparam int COORD_BITS = 16;
  localparam int NSTAGE     = 16;
  localparam int MAX_TABLE  = 24;
  localparam int STAGES     = (NSTAGE < MAX_TABLE) ? NSTAGE : MAX_TABLE;
  localparam int SCALE      = 38 - COORD_BITS;
  localparam int XW         = COORD_BITS + 1 + SCALE + 3;
  localparam int ZW         = 27;
  localparam int VW         = 43;
  localparam int SHW        = 5;

  localparam int SPEED_W = 10;
  localparam int KIND_W  = 4;
  localparam int IDX_W   = 4;
  localparam int DATA_W  = 10;

  localparam logic [IDX_W-1:0]  REG_MAX_SPEED = 4'd0;
  localparam logic [IDX_W-1:0]  REG_PROJ_KIND = 4'd1;
  localparam logic [KIND_W-1:0] MIRROR_KIND   = 4'd5;

  localparam logic [29:0] KINV_Q30 = 30'd652032874;
  localparam logic signed [ZW-1:0] DEG180_Q16 = ZW'(180 * 65536);
  localparam logic signed [15:0] HEAD_LIMIT = 16'sd23040;
  localparam logic signed [15:0] RIGHT_Q7   = 16'sd11520;

  typedef logic signed [XW-1:0] xw_t;
  typedef logic signed [ZW-1:0] zw_t;
  typedef logic signed [VW-1:0] vw_t;

  // State handed from cell to cell.
  typedef struct packed {
    logic        valid;
    xw_t         x;
    xw_t         y;
    zw_t         z;
    vw_t         vx;
    vw_t         vy;
    logic        flip;
    logic        degenerate;
    logic        mirror_en;
  } avva_vec_t;

  // atan(2^-i) in degrees, Q.16
  function automatic zw_t atan_deg(input logic [SHW-1:0] i);
    case (i)
      5'd0:  atan_deg = zw_t'(2949120);
      5'd1:  atan_deg = zw_t'(1740967);
      5'd2:  atan_deg = zw_t'(919879);
      5'd3:  atan_deg = zw_t'(466945);
      5'd4:  atan_deg = zw_t'(234379);
      5'd5:  atan_deg = zw_t'(117304);
      5'd6:  atan_deg = zw_t'(58666);
      5'd7:  atan_deg = zw_t'(29335);
      5'd8:  atan_deg = zw_t'(14668);
      5'd9:  atan_deg = zw_t'(7334);
      5'd10: atan_deg = zw_t'(3667);
      5'd11: atan_deg = zw_t'(1833);
      5'd12: atan_deg = zw_t'(917);
      5'd13: atan_deg = zw_t'(458);
      5'd14: atan_deg = zw_t'(229);
      5'd15: atan_deg = zw_t'(115);
      5'd16: atan_deg = zw_t'(57);
      5'd17: atan_deg = zw_t'(29);
      5'd18: atan_deg = zw_t'(14);
      5'd19: atan_deg = zw_t'(7);
      5'd20: atan_deg = zw_t'(4);
      5'd21: atan_deg = zw_t'(2);
      5'd22: atan_deg = zw_t'(1);
      default: atan_deg = '0;
    endcase
  endfunction

endpackage

FILE: hdl/avva_if.sv
// Request and response channel interfaces of the aiming unit.
interface avva_req_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] shooter_x;
  logic signed [15:0] shooter_y;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  modport source (output valid, shooter_x, shooter_y, target_x, target_y, input ready);
  modport sink (input valid, shooter_x, shooter_y, target_x, target_y, output ready);
endinterface

interface avva_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] velocity_x;
  logic signed [16:0] velocity_y;
  logic signed [15:0] heading_deg;
  logic               mirror;
  logic               degenerate;
  modport source (output valid, velocity_x, velocity_y, heading_deg, mirror, degenerate,
                  input ready);
  modport sink (input valid, velocity_x, velocity_y, heading_deg, mirror, degenerate,
                output ready);
endinterface

FILE: hdl/avva_cell.sv
// One CORDIC cell: a vectoring step and the matching velocity rotation.
module avva_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [avva_pkg::SHW-1:0] stage,
  input  avva_pkg::avva_vec_t      d,
  output avva_pkg::avva_vec_t      q
);
  import avva_pkg::*;

  avva_vec_t q_next;
  logic      dir;
  xw_t       xs, ys;
  vw_t       vxs, vys;
  zw_t       ang;

  always_comb begin
    dir = (d.y >= 0);
    xs  = d.x >>> stage;
    ys  = d.y >>> stage;
    vxs = d.vx >>> stage;
    vys = d.vy >>> stage;
    ang = atan_deg(stage);
    q_next = d;
    if (dir) begin
      q_next.x  = d.x + ys;
      q_next.y  = d.y - xs;
      q_next.z  = d.z + ang;
      q_next.vx = d.vx - vys;
      q_next.vy = d.vy + vxs;
    end else begin
      q_next.x  = d.x - ys;
      q_next.y  = d.y + xs;
      q_next.z  = d.z - ang;
      q_next.vx = d.vx + vys;
      q_next.vy = d.vy - vxs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

FILE: hdl/aim_vector_velocity_angle.sv
// Aiming unit: difference vector to scaled velocity, heading and mirror flag.
// Channels: req carries shooter and target points, rsp carries velocity_x,
// velocity_y (Q11.6), heading_deg (Q9.7 degrees), mirror and degenerate.
// A beat moves on a channel when valid and ready are both high.
// Configuration: cfg_we with cfg_index 0 writes max_speed, index 1 writes
// projectile_kind; other indexes are ignored. Both reset to 0.
// Path from request beat to response valid: one entry register, one
// register per CORDIC cell, one output register. Throughput: one beat per
// cycle while the receiver takes responses, set by the row of cells, each
// of which holds one item.
// Reset (synchronous, rst high) empties the pipeline; no clearing pass.
// When the receiver stalls, the whole pipeline holds and req.ready drops
// only while a finished response waits untaken in the output register.
module aim_vector_velocity_angle (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [avva_pkg::IDX_W-1:0]   cfg_index,
  input  logic [avva_pkg::DATA_W-1:0]  cfg_data,
  avva_req_if.sink                     req,
  avva_rsp_if.source                   rsp
);
  import avva_pkg::*;

  logic [SPEED_W-1:0] max_speed;
  logic [KIND_W-1:0]  projectile_kind;
  logic               adv;

  avva_vec_t chain [STAGES+1];
  avva_vec_t entry_next;

  logic signed [COORD_BITS:0] dx, dy;

  logic               rsp_valid;
  logic signed [16:0] vel_x, vel_y;
  logic signed [15:0] head;
  logic               mir, degen;

  vw_t                vxf, vyf, vxr, vyr;
  zw_t                zr;
  logic signed [16:0] vx_sat, vy_sat;
  logic signed [15:0] head_sat;
  avva_vec_t          last;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed       <= '0;
      projectile_kind <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_SPEED: max_speed <= cfg_data[SPEED_W-1:0];
        REG_PROJ_KIND: projectile_kind <= cfg_data[KIND_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance everything unless a response is held.
  assign adv       = !rsp_valid || rsp.ready;
  assign req.ready = adv;

  always_comb begin
    dx = (COORD_BITS+1)'($signed(req.target_x[COORD_BITS-1:0]))
       - (COORD_BITS+1)'($signed(req.shooter_x[COORD_BITS-1:0]));
    dy = (COORD_BITS+1)'($signed(req.target_y[COORD_BITS-1:0]))
       - (COORD_BITS+1)'($signed(req.shooter_y[COORD_BITS-1:0]));
    entry_next.valid      = req.valid;
    entry_next.degenerate = (dx == 0) && (dy == 0);
    entry_next.flip       = dx < 0;
    entry_next.mirror_en  = projectile_kind == MIRROR_KIND;
    entry_next.x          = XW'(dx) <<< SCALE;
    entry_next.y          = XW'(dy) <<< SCALE;
    entry_next.z          = '0;
    if (dx < 0) begin
      entry_next.x = -entry_next.x;
      entry_next.y = -entry_next.y;
      entry_next.z = (dy >= 0) ? DEG180_Q16 : -DEG180_Q16;
    end
    entry_next.vx = $signed(VW'(max_speed * KINV_Q30));
    entry_next.vy = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (adv) begin
      chain[0] <= entry_next;
    end
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    avva_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (adv),
      .stage (SHW'(g)),
      .d     (chain[g]),
      .q     (chain[g+1])
    );
  end

  // Undo the flip, round half up and saturate.
  always_comb begin
    last = chain[STAGES];
    vxf  = last.flip ? -last.vx : last.vx;
    vyf  = last.flip ? -last.vy : last.vy;
    vxr  = (vxf + vw_t'(1 << 23)) >>> 24;
    vyr  = (vyf + vw_t'(1 << 23)) >>> 24;
    zr   = (last.z + zw_t'(256)) >>> 9;
    if (vxr < -65536)     vx_sat = -17'sd65536;
    else if (vxr > 65535) vx_sat = 17'sd65535;
    else                  vx_sat = vxr[16:0];
    if (vyr < -65536)     vy_sat = -17'sd65536;
    else if (vyr > 65535) vy_sat = 17'sd65535;
    else                  vy_sat = vyr[16:0];
    if (zr < -23040)      head_sat = -HEAD_LIMIT;
    else if (zr > 23040)  head_sat = HEAD_LIMIT;
    else                  head_sat = zr[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= last.valid;
      degen     <= last.degenerate;
      if (last.degenerate) begin
        vel_x <= '0;
        vel_y <= '0;
        head  <= '0;
        mir   <= 1'b0;
      end else begin
        vel_x <= vx_sat;
        vel_y <= vy_sat;
        head  <= head_sat;
        mir   <= last.mirror_en && (head_sat > RIGHT_Q7 || head_sat <= -RIGHT_Q7);
      end
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.velocity_x  = vel_x;
  assign rsp.velocity_y  = vel_y;
  assign rsp.heading_deg = head;
  assign rsp.mirror      = mir;
  assign rsp.degenerate  = degen;

endmodule

FILE: test/aim_vector_velocity_angle_tb.sv
// Self-checking testbench for the aiming unit: directed table, random beats, random stalls.
module aim_vector_velocity_angle_tb;
  import avva_pkg::*;

  localparam int PIPE_DEPTH = STAGES + 2;
  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_PER_PHASE = 190;

  typedef struct {
    logic signed [16:0] vel_x;
    logic signed [16:0] vel_y;
    logic signed [15:0] heading;
    logic               mirror;
    logic               degenerate;
  } aim_result_t;

  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    bit                 typed;
  } aim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [DATA_W-1:0]   cfg_data = '0;

  avva_req_if req ();
  avva_rsp_if rsp ();

  aim_vector_velocity_angle DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req.sink),
    .rsp       (rsp.source)
  );

  always #2 clk = ~clk;

  // Mirror of the configuration registers
  logic [SPEED_W-1:0] speed_cfg = '0;
  logic [KIND_W-1:0]  kind_cfg = '0;

  aim_result_t pending_aims[$];
  int          errors = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          degenerate_seen = 0;
  int          mirror_seen = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  int          stall_left = 0;

  longint atan_q16[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                           14668, 7334, 3667, 1833, 917, 458, 229, 115,
                           57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic aim_result_t aim_solve(logic signed [15:0] sx, logic signed [15:0] sy,
                                            logic signed [15:0] tx, logic signed [15:0] ty);
    aim_result_t r;
    longint dx, dy, x, y, z, vx, vy, xs, ys, hd;
    bit turn_up[24];
    bit flip;
    dx = longint'(tx) - longint'(sx);
    dy = longint'(ty) - longint'(sy);
    r = '{default: '0};
    if (dx == 0 && dy == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    x = dx * (longint'(1) <<< SCALE);
    y = dy * (longint'(1) <<< SCALE);
    z = 0;
    flip = (dx < 0);
    if (flip) begin
      x = -x;
      y = -y;
      z = (dy >= 0) ? 180 * 65536 : -180 * 65536;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      turn_up[i] = (y >= 0);
      if (turn_up[i]) begin
        x = x + ys; y = y - xs; z = z + atan_q16[i];
      end else begin
        x = x - ys; y = y + xs; z = z - atan_q16[i];
      end
    end
    // Replay the same rotations on the pre-scaled speed
    vx = longint'(speed_cfg) * longint'(KINV_Q30);
    vy = 0;
    for (int i = 0; i < STAGES; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (turn_up[i]) begin
        vx = vx - ys; vy = vy + xs;
      end else begin
        vx = vx + ys; vy = vy - xs;
      end
    end
    if (flip) begin
      vx = -vx;
      vy = -vy;
    end
    r.vel_x = 17'(clamp((vx + (longint'(1) <<< 23)) >>> 24, -65536, 65535));
    r.vel_y = 17'(clamp((vy + (longint'(1) <<< 23)) >>> 24, -65536, 65535));
    hd = clamp((z + 256) >>> 9, -23040, 23040);
    r.heading = 16'(hd);
    r.mirror = (hd > 11520 || hd <= -11520) && kind_cfg == MIRROR_KIND;
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Response side: random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp.ready <= 1'b1;
      stall_left <= gap_len();
    end
  end

  // Check each response beat against the oldest expectation
  always @(posedge clk) begin
    aim_result_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      beats_out++;
      if (pending_aims.size() == 0) begin
        $error("response beat with nothing expected");
        errors++;
      end else begin
        e = pending_aims.pop_front();
        if (rsp.velocity_x !== e.vel_x) begin
          $error("velocity_x: expected %0d, got %0d", e.vel_x, rsp.velocity_x);
          errors++;
        end
        if (rsp.velocity_y !== e.vel_y) begin
          $error("velocity_y: expected %0d, got %0d", e.vel_y, rsp.velocity_y);
          errors++;
        end
        if (rsp.heading_deg !== e.heading) begin
          $error("heading_deg: expected %0d, got %0d", e.heading, rsp.heading_deg);
          errors++;
        end
        if (rsp.mirror !== e.mirror) begin
          $error("mirror: expected %0b, got %0b", e.mirror, rsp.mirror);
          errors++;
        end
        if (rsp.degenerate !== e.degenerate) begin
          $error("degenerate: expected %0b, got %0b", e.degenerate, rsp.degenerate);
          errors++;
        end
        degenerate_seen += e.degenerate;
        mirror_seen += e.mirror;
      end
    end
  end

  // Watchdog: stop when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_aim(logic signed [15:0] sx, logic signed [15:0] sy,
                          logic signed [15:0] tx, logic signed [15:0] ty,
                          bit typed, aim_result_t typed_res);
    int g;
    req.valid <= 1'b1;
    req.shooter_x <= sx;
    req.shooter_y <= sy;
    req.target_x <= tx;
    req.target_y <= ty;
    do @(posedge clk); while (!req.ready);
    beats_in++;
    pending_aims.push_back(typed ? typed_res : aim_solve(sx, sy, tx, ty));
    g = gap_len();
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Hold off until every response is back and the pipeline has emptied
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_aims.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 6) @(posedge clk);
  endtask

  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_SPEED) speed_cfg = data[SPEED_W-1:0];
    else if (idx == REG_PROJ_KIND) kind_cfg = data[KIND_W-1:0];
  endtask

  task automatic random_aims(int count);
    logic signed [15:0] sx, sy, tx, ty;
    aim_result_t none;
    none = '{default: '0};
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      sx = 16'($urandom);
      sy = 16'($urandom);
      case ($urandom_range(0, 9))
        0: begin tx = sx; ty = sy; end
        1: begin tx = sx + 16'($signed($urandom_range(0, 6)) - 3); ty = sy; end
        2: begin tx = sx; ty = sy + 16'($signed($urandom_range(0, 6)) - 3); end
        3, 4: begin
          tx = sx + 16'($signed($urandom_range(0, 64)) - 32);
          ty = sy + 16'($signed($urandom_range(0, 64)) - 32);
        end
        5: begin
          sx = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          sy = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          tx = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          ty = 16'($urandom);
        end
        default: begin tx = 16'($urandom); ty = 16'($urandom); end
      endcase
      send_aim(sx, sy, tx, ty, 1'b0, none);
    end
    calm = 1'b0;
  endtask

  aim_row_t aim_table[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1},
    '{16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, 1'b1},
    '{16'sd0, 16'sd0, 16'sd100, 16'sd0, 1'b0},
    '{16'sd0, 16'sd0, -16'sd100, 16'sd0, 1'b0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd5, 1'b0},
    '{16'sd0, 16'sd0, 16'sd0, -16'sd5, 1'b0},
    '{16'sd0, 16'sd0, 16'sd1, 16'sd0, 1'b0},
    '{16'sd0, 16'sd0, -16'sd1, 16'sd0, 1'b0},
    '{16'sd0, 16'sd0, 16'sd1, 16'sd1, 1'b0},
    '{16'sd0, 16'sd0, -16'sd1, 16'sd1, 1'b0},
    '{16'sd0, 16'sd0, -16'sd1, -16'sd1, 1'b0},
    '{16'sd0, 16'sd0, 16'sd1, -16'sd1, 1'b0},
    '{-16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0},
    '{16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, 1'b0},
    '{16'sh7fff, 16'sd0, -16'sh8000, 16'sd0, 1'b0},
    '{-16'sh8000, 16'sd0, 16'sh7fff, 16'sd0, 1'b0},
    '{16'sd0, -16'sh8000, 16'sd0, 16'sh7fff, 1'b0},
    '{16'sd0, 16'sh7fff, 16'sd0, -16'sh8000, 1'b0},
    '{16'sd10, 16'sd10, 16'sd9, 16'sd11, 1'b0},
    '{16'sd10, 16'sd10, 16'sd9, 16'sd9, 1'b0},
    '{16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff, 1'b0}
  };

  initial begin
    aim_result_t blank;
    blank = '{default: '0};
    req.valid = 1'b0;
    req.shooter_x = '0;
    req.shooter_y = '0;
    req.target_x = '0;
    req.target_y = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: zero speed, no mirroring
    random_aims(40);
    drain();

    cfg_write(REG_MAX_SPEED, 10'd1023);
    cfg_write(REG_PROJ_KIND, 10'h3f5);
    cfg_write(4'd7, 10'h3ff);
    foreach (aim_table[i]) begin
      blank.degenerate = aim_table[i].typed;
      send_aim(aim_table[i].sx, aim_table[i].sy, aim_table[i].tx, aim_table[i].ty,
               aim_table[i].typed, blank);
    end
    random_aims(RANDOM_PER_PHASE);
    drain();

    cfg_write(REG_MAX_SPEED, 10'd1);
    random_aims(RANDOM_PER_PHASE);
    drain();

    cfg_write(REG_MAX_SPEED, 10'd517);
    cfg_write(REG_PROJ_KIND, 10'd3);
    random_aims(RANDOM_PER_PHASE);
    drain();

    cfg_write(REG_MAX_SPEED, 10'd1023);
    cfg_write(REG_PROJ_KIND, 10'd15);
    random_aims(RANDOM_PER_PHASE / 2);
    drain();
    cfg_write(REG_PROJ_KIND, 10'd5);
    random_aims(RANDOM_PER_PHASE);
    drain();

    $display("Covered %0d request beats and %0d response beats over six settings",
             beats_in, beats_out);
    $display("Degenerate results %0d, mirrored headings %0d, mismatches %0d",
             degenerate_seen, mirror_seen, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
